[design/sync_header_packet_framer_crc8_unit_macros.svh]
// Assertion helpers shared by the framer modules.
`ifndef SYNC_HEADER_PACKET_FRAMER_CRC8_UNIT_MACROS_SVH
`define SYNC_HEADER_PACKET_FRAMER_CRC8_UNIT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define SHPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define SHPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[design/shpf_pkg.sv]
`timescale 1ns / 1ps
package shpf_pkg;

  localparam int unsigned PacketLenDef = 17;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned OutDataW     = 16;

  localparam logic [ByteW-1:0] HdrA    = 8'h55;
  localparam logic [ByteW-1:0] HdrB    = 8'hAA;
  localparam logic [ByteW-1:0] CrcPoly = 8'h07;
  localparam logic [ByteW-1:0] CrcMsb  = 8'h80;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_header(input logic [ByteW-1:0] b);
    return (b == HdrA) || (b == HdrB);
  endfunction

endpackage

[design/shpf_ram.sv]
`timescale 1ns / 1ps
module shpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/shpf_rx.sv]
`timescale 1ns / 1ps
`include "sync_header_packet_framer_crc8_unit_macros.svh"
module shpf_rx
  import shpf_pkg::*;
#(
  parameter int unsigned PacketLen = PacketLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [ByteW-1:0]             byte_i,
  input  logic                         busy_i,
  output logic                         we_o,
  output logic [$clog2(PacketLen)-1:0] waddr_o,
  output logic [ByteW-1:0]             wdata_o,
  output logic                         start_o
);

  localparam int unsigned AW = $clog2(PacketLen);
  localparam logic [AW-1:0] LastPos = AW'(PacketLen - 1);

  typedef enum logic [1:0] {
    HUNT,
    WAIT,
    COLLECT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic             accept;
  logic             hdr_match;

  assign ready_o   = !busy_i;
  assign accept    = valid_i && ready_o;
  assign wdata_o   = byte_i;
  assign hdr_match = ((first_q == HdrA) && (byte_i == HdrB)) ||
                     ((first_q == HdrB) && (byte_i == HdrA));

  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    we_o    = 1'b0;
    waddr_o = '0;
    start_o = 1'b0;
    if (accept) begin
      unique case (phase_q)
        WAIT: begin
          if (hdr_match) begin
            we_o    = 1'b1;
            waddr_o = AW'(1);
            crc_d   = crc8_update(crc_q, byte_i);
            cnt_d   = AW'(2);
            phase_d = COLLECT;
          end else if (is_header(byte_i)) begin
            // restart the second-byte wait with the newer header byte
            we_o    = 1'b1;
            first_d = byte_i;
            crc_d   = crc8_update('0, byte_i);
          end else begin
            phase_d = HUNT;
          end
        end
        COLLECT: begin
          we_o    = 1'b1;
          waddr_o = cnt_q;
          if (cnt_q == LastPos) begin
            start_o = (crc_q == byte_i);
            phase_d = HUNT;
            cnt_d   = '0;
            crc_d   = '0;
          end else begin
            crc_d = crc8_update(crc_q, byte_i);
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          phase_d = HUNT;
          if (is_header(byte_i)) begin
            we_o    = 1'b1;
            first_d = byte_i;
            crc_d   = crc8_update('0, byte_i);
            phase_d = WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HUNT;
      first_q <= '0;
      cnt_q   <= '0;
      crc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
    end
  end

  `SHPF_ASSERT(a_start_on_beat, start_o |-> (accept && phase_q == COLLECT), "start without final beat")
  `SHPF_ASSERT(a_cnt_range, (phase_q == COLLECT) |-> (cnt_q >= AW'(2) && cnt_q <= LastPos), "byte count out of range")
  `SHPF_ASSERT(a_hdr_lock, (accept && phase_q == WAIT && hdr_match) |=> (phase_q == COLLECT && cnt_q == AW'(2)), "header not locked")

endmodule

[design/shpf_tx.sv]
`timescale 1ns / 1ps
`include "sync_header_packet_framer_crc8_unit_macros.svh"
module shpf_tx
  import shpf_pkg::*;
#(
  parameter int unsigned PacketLen = PacketLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  output logic                         re_o,
  output logic [$clog2(PacketLen)-1:0] raddr_o,
  input  logic [ByteW-1:0]             rdata_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [OutDataW-1:0]          data_o,
  output logic                         last_o
);

  localparam int unsigned AW = $clog2(PacketLen);
  localparam logic [AW-1:0] LastPos = AW'(PacketLen - 1);

  typedef enum logic [1:0] {
    IDLE,
    ISSUE,
    SHOW
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          at_last;

  assign at_last = (idx_q == LastPos);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    re_o    = 1'b0;
    raddr_o = idx_q;
    unique case (state_q)
      ISSUE: begin
        re_o    = 1'b1;
        state_d = SHOW;
      end
      SHOW: begin
        if (ready_i) begin
          if (at_last) begin
            state_d = IDLE;
          end else begin
            // fetch the next byte as this beat leaves
            re_o    = 1'b1;
            raddr_o = idx_q + 1'b1;
            idx_d   = idx_q + 1'b1;
          end
        end
      end
      default: begin
        if (start_i) begin
          idx_d   = '0;
          state_d = ISSUE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o  = (state_q != IDLE);
  assign valid_o = (state_q == SHOW);
  assign last_o  = valid_o && at_last;
  assign data_o  = {(OutDataW - ByteW - IdxW)'(0), IdxW'(idx_q), rdata_i};

  `SHPF_ASSERT(a_start_idle, start_i |-> (state_q == IDLE), "start while busy")
  `SHPF_ASSERT(a_end_of_run, (valid_o && ready_i && last_o) |=> !valid_o, "run continues past last")
  `SHPF_ASSERT(a_idx_step, (valid_o && ready_i && !last_o) |=> (valid_o && idx_q == $past(idx_q) + 1'b1), "index skipped")

endmodule

[design/sync_header_packet_framer_crc8_unit.sv]
`timescale 1ns / 1ps
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata[7:0] pkt_byte, tdata[13:8] byte_index, tlast last_byte
//
// A verified packet is read back from the packet RAM: the first byte is read and
// registered and shown, then one beat per cycle while m_axis is ready, PacketLen
// beats in all; the single RAM read port sets that pace. After a checking byte
// that matches the CRC, s_axis stays not ready until the last beat is taken.
// m_axis stalls hold the current beat. Reset is asynchronous; RAM is not cleared.
module sync_header_packet_framer_crc8_unit
  import shpf_pkg::*;
#(
  parameter int unsigned PacketLen = PacketLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] pkt_byte, [13:8] byte_index
  output logic                m_axis_tlast
);

  localparam int unsigned AW = $clog2(PacketLen);

  logic             we;
  logic [AW-1:0]    waddr;
  logic [ByteW-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [ByteW-1:0] rdata;
  logic             start;
  logic             busy;

  // Hunt for the header, store bytes, run the CRC.
  shpf_rx #(
    .PacketLen(PacketLen)
  ) u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .byte_i (s_axis_tdata),
    .busy_i (busy),
    .we_o   (we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .start_o(start)
  );

  // Packet store: written per stored packet byte, read back on a good CRC.
  shpf_ram #(
    .Width(ByteW),
    .Depth(PacketLen)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Replay the stored packet as a run of beats.
  shpf_tx #(
    .PacketLen(PacketLen)
  ) u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .re_o   (re),
    .raddr_o(raddr),
    .rdata_i(rdata),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

endmodule
